>>> hw/rtl/setok_pkg.sv
// Shared types and constants for the S-expression tokenizer.
// Depends on nothing; every other file but setok_if imports it.
package setok_pkg;

   // Result kind codes as they appear on the result channel.
   typedef enum logic [3:0] {
      KIND_OPEN   = 4'd0,
      KIND_CLOSE  = 4'd1,
      KIND_ID     = 4'd2,
      KIND_INT    = 4'd3,
      KIND_FLOAT  = 4'd4,
      KIND_BOOL   = 4'd5,
      KIND_STRING = 4'd6,
      KIND_NIL    = 4'd7,
      KIND_BYTE   = 4'd8
   } kind_type;

   // Lexer modes.
   typedef enum logic [1:0] {
      MODE_READ    = 2'd0,
      MODE_TOKEN   = 2'd1,
      MODE_STRING  = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   // Keyword prefix tracker: which of "#t", "#f", "#nil" still matches.
   typedef enum logic [2:0] {
      KW_START = 3'd0,
      KW_HASH  = 3'd1,
      KW_T     = 3'd2,
      KW_F     = 3'd3,
      KW_N     = 3'd4,
      KW_NI    = 3'd5,
      KW_NIL   = 3'd6,
      KW_NONE  = 3'd7
   } kw_type;

   // Character constants.
   localparam logic [7:0] CHAR_OPEN    = 8'h28;
   localparam logic [7:0] CHAR_CLOSE   = 8'h29;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_QUOTE   = 8'h27;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_LOW_T   = 8'h74;
   localparam logic [7:0] CHAR_LOW_F   = 8'h66;
   localparam logic [7:0] CHAR_LOW_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOW_I   = 8'h69;
   localparam logic [7:0] CHAR_LOW_L   = 8'h6C;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_END_LO  = 8'h00;
   localparam logic [7:0] CHAR_END_HI  = 8'hFF;

   // Depth of the queue between the lexer front and the output back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // One result item without its last flag.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_out;
      logic [8:0] token_length;
      logic       too_long;
   } result_type;

   // Everything one input byte produces: one or two results.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   // Advance the keyword prefix tracker by one byte.
   function automatic kw_type kw_next(kw_type kw, logic [7:0] b);
      kw_type nxt;
      case (kw)
         KW_START: nxt = (b == CHAR_HASH) ? KW_HASH : KW_NONE;
         KW_HASH: begin
            if (b == CHAR_LOW_T) nxt = KW_T;
            else if (b == CHAR_LOW_F) nxt = KW_F;
            else if (b == CHAR_LOW_N) nxt = KW_N;
            else nxt = KW_NONE;
         end
         KW_N:  nxt = (b == CHAR_LOW_I) ? KW_NI : KW_NONE;
         KW_NI: nxt = (b == CHAR_LOW_L) ? KW_NIL : KW_NONE;
         default: nxt = KW_NONE;
      endcase
      return nxt;
   endfunction

endpackage

>>> hw/rtl/setok_if.sv
// Valid/ready channel interfaces for the tokenizer's input bytes and results.
// Depends on nothing beyond plain logic types.
interface setok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface setok_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] kind;
   logic [7:0] char_out;
   logic [8:0] token_length;
   logic       too_long;
   logic       last;

   modport source (output valid, output kind, output char_out, output token_length,
                   output too_long, output last, input ready);
   modport sink   (input valid, input kind, input char_out, input token_length,
                   input too_long, input last, output ready);
endinterface

>>> hw/rtl/setok_front.sv
// Lexer front: takes one byte per transfer, keeps the lexer state and
// builds the one or two results the byte causes. Depends on setok_pkg.
module setok_front #(
   parameter int MAX_TEXT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   output logic                  byte_ready,
   input  logic [7:0]            text_byte,
   output logic                  push,
   input  logic                  push_ready,
   output setok_pkg::entry_type  push_entry
);
   import setok_pkg::*;

   localparam int LEN_W = $clog2(MAX_TEXT + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TEXT);

   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             digits_ff, digits_in;
   logic [1:0]       dots_ff, dots_in;
   kw_type           kw_ff, kw_in;
   logic             ovf_ff, ovf_in;

   logic             accept;
   logic             paren_byte, is_space, is_digit, is_end;
   kind_type         paren_kind, tok_kind;
   logic [LEN_W+8:0] len_wide;
   logic [8:0]       len9;
   entry_type        entry;
   logic             has_result;

   // The front stalls only when the queue has no room.
   assign byte_ready = push_ready;
   assign accept     = byte_valid && push_ready;
   assign push       = accept && has_result;
   assign push_entry = entry;

   // Byte classes.
   assign paren_byte = (text_byte == CHAR_OPEN) || (text_byte == CHAR_CLOSE);
   assign paren_kind = (text_byte == CHAR_OPEN) ? KIND_OPEN : KIND_CLOSE;
   assign is_space   = (text_byte == CHAR_SPACE) ||
                       ((text_byte >= CHAR_TAB) && (text_byte <= CHAR_CR));
   assign is_digit   = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
   assign is_end     = (text_byte == CHAR_END_LO) || (text_byte == CHAR_END_HI);

   // Reported length is the run length modulo 512.
   assign len_wide = {9'd0, len_ff};
   assign len9     = len_wide[8:0];

   // Class of the token that ends with this byte, by priority.
   always_comb begin
      if (kw_ff == KW_NIL) tok_kind = KIND_NIL;
      else if ((kw_ff == KW_T) || (kw_ff == KW_F)) tok_kind = KIND_BOOL;
      else if (digits_ff && (dots_ff == 2'd1)) tok_kind = KIND_FLOAT;
      else if (digits_ff && (dots_ff == 2'd0)) tok_kind = KIND_INT;
      else tok_kind = KIND_ID;
   end

   // Lexer step: next state and the results of this byte.
   always_comb begin
      mode_in    = mode_ff;
      len_in     = len_ff;
      digits_in  = digits_ff;
      dots_in    = dots_ff;
      kw_in      = kw_ff;
      ovf_in     = ovf_ff;
      entry      = '0;
      has_result = 1'b0;

      if (is_end) begin
         mode_in   = MODE_READ;
         len_in    = '0;
         digits_in = 1'b1;
         dots_in   = 2'd0;
         kw_in     = KW_START;
         ovf_in    = 1'b0;
      end else begin
         case (mode_ff)
            MODE_COMMENT: begin
               if (text_byte == CHAR_NL) mode_in = MODE_READ;
            end
            MODE_STRING: begin
               has_result = 1'b1;
               if (text_byte == CHAR_QUOTE) begin
                  entry.first.kind         = KIND_STRING;
                  entry.first.token_length = len9;
                  entry.first.too_long     = ovf_ff;
                  mode_in   = MODE_READ;
                  len_in    = '0;
                  digits_in = 1'b1;
                  dots_in   = 2'd0;
                  kw_in     = KW_START;
                  ovf_in    = 1'b0;
               end else begin
                  if (len_ff < MAX_LEN) len_in = len_ff + LEN_W'(1);
                  else ovf_in = 1'b1;
                  entry.first.kind     = KIND_BYTE;
                  entry.first.char_out = text_byte;
               end
            end
            MODE_TOKEN: begin
               has_result = 1'b1;
               if (paren_byte || is_space || (text_byte == CHAR_SEMI)) begin
                  entry.first.kind         = tok_kind;
                  entry.first.token_length = len9;
                  entry.first.too_long     = ovf_ff;
                  if (paren_byte) begin
                     entry.two         = 1'b1;
                     entry.second.kind = paren_kind;
                  end
                  mode_in   = (text_byte == CHAR_SEMI) ? MODE_COMMENT : MODE_READ;
                  len_in    = '0;
                  digits_in = 1'b1;
                  dots_in   = 2'd0;
                  kw_in     = KW_START;
                  ovf_in    = 1'b0;
               end else begin
                  if (len_ff < MAX_LEN) len_in = len_ff + LEN_W'(1);
                  else ovf_in = 1'b1;
                  if (text_byte == CHAR_DOT) begin
                     if (dots_ff != 2'd2) dots_in = dots_ff + 2'd1;
                  end else if (!is_digit) begin
                     digits_in = 1'b0;
                  end
                  kw_in = kw_next(kw_ff, text_byte);
                  entry.first.kind     = KIND_BYTE;
                  entry.first.char_out = text_byte;
               end
            end
            default: begin
               if (paren_byte) begin
                  has_result       = 1'b1;
                  entry.first.kind = paren_kind;
               end else if (text_byte == CHAR_SEMI) begin
                  mode_in = MODE_COMMENT;
               end else if (is_space) begin
                  mode_in = MODE_READ;
               end else if (text_byte == CHAR_QUOTE) begin
                  mode_in   = MODE_STRING;
                  len_in    = '0;
                  digits_in = 1'b1;
                  dots_in   = 2'd0;
                  kw_in     = KW_START;
                  ovf_in    = 1'b0;
               end else begin
                  // A token starts: its first byte is counted and classed.
                  has_result = 1'b1;
                  mode_in    = MODE_TOKEN;
                  len_in     = LEN_W'(1);
                  ovf_in     = 1'b0;
                  digits_in  = is_digit || (text_byte == CHAR_DOT);
                  dots_in    = (text_byte == CHAR_DOT) ? 2'd1 : 2'd0;
                  kw_in      = kw_next(KW_START, text_byte);
                  entry.first.kind     = KIND_BYTE;
                  entry.first.char_out = text_byte;
               end
            end
         endcase
      end
   end

   // State registers advance on every accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_READ;
         len_ff    <= '0;
         digits_ff <= 1'b1;
         dots_ff   <= 2'd0;
         kw_ff     <= KW_START;
         ovf_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         digits_ff <= digits_in;
         dots_ff   <= dots_in;
         kw_ff     <= kw_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

>>> hw/rtl/setok_queue.sv
// Short queue of result entries between the lexer front and the back.
// Depends on setok_pkg for the entry type and depth.
module setok_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  push_ready,
   input  setok_pkg::entry_type  push_entry,
   output logic                  pop_valid,
   input  logic                  pop,
   output setok_pkg::entry_type  pop_entry
);
   import setok_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

>>> hw/rtl/setok_back.sv
// Output back: splits each queue entry into one or two result transfers and
// holds them in an output register. Depends on setok_pkg and setok_if.
module setok_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop,
   input  setok_pkg::entry_type  pop_entry,
   setok_rsp_if.source           rsp_chan
);
   import setok_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       out_last_ff, out_last_in;
   logic       hold_valid_ff, hold_valid_in;
   result_type hold_ff, hold_in;
   logic       out_free;

   // The output register can load when empty or being taken this cycle.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign pop      = out_free && !hold_valid_ff && pop_valid;

   // Load the pending second result first, then the next queue entry.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (out_free) begin
         if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = hold_ff;
            out_last_in   = 1'b1;
            hold_valid_in = 1'b0;
         end else if (pop_valid) begin
            out_valid_in  = 1'b1;
            out_in        = pop_entry.first;
            out_last_in   = !pop_entry.two;
            hold_valid_in = pop_entry.two;
            hold_in       = pop_entry.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      hold_ff     <= hold_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_ff.kind;
   assign rsp_chan.char_out     = out_ff.char_out;
   assign rsp_chan.token_length = out_ff.token_length;
   assign rsp_chan.too_long     = out_ff.too_long;
   assign rsp_chan.last         = out_last_ff;

endmodule

>>> hw/rtl/s_expression_tokenizer_core.sv
// Top level of the streaming S-expression tokenizer.
// Depends on setok_pkg, setok_if, setok_front, setok_queue and setok_back.
//
// The tokenizer takes one text byte per transfer and returns paren, token,
// string and text-byte results in order, each byte's final result marked by
// last. A new byte is accepted every cycle while the four-entry result queue
// has room; a byte causes at most one queue entry. Most bytes give at most one
// result, so the sustained rate is one byte per cycle while the result channel
// does not stall. A byte that ends a token with a paren gives two results on
// the result channel, so the long-run rate is one result per cycle, set by the
// single output register. A byte's first result passes through a queue slot
// and then the output register. Bytes 0x00 and 0xFF end the text, drop any
// pending token and give no result. Token lengths saturate at MAX_TEXT with
// too_long set and are reported modulo 512.
module s_expression_tokenizer_core #(
   parameter int MAX_TEXT = 256
) (
   input  logic        clock,
   input  logic        reset,
   setok_req_if.sink   req_chan,
   setok_rsp_if.source rsp_chan
);
   import setok_pkg::*;

   logic      push, push_ready, pop_valid, pop;
   entry_type push_entry, pop_entry;

   setok_front #(
      .MAX_TEXT (MAX_TEXT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_chan.valid),
      .byte_ready (req_chan.ready),
      .text_byte  (req_chan.text_byte),
      .push       (push),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   setok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   setok_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> dv/s_expression_tokenizer_core_test.sv
// Self-checking testbench for the streaming S-expression tokenizer core.
// Depends on setok_pkg, setok_if and s_expression_tokenizer_core from the RTL.
// A byte-level lexer model predicts every result, which is checked as it arrives.
module s_expression_tokenizer_core_test;
   import setok_pkg::*;

   localparam int TEXT_LIMIT   = 256;
   localparam int RANDOM_ITEMS = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT    = 8_000_000;

   // One expected result, last flag included.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_out;
      logic [8:0] token_length;
      logic       too_long;
      logic       last;
   } lex_result_type;

   logic clock = 1'b0;
   logic reset;

   setok_req_if req_chan ();
   setok_rsp_if rsp_chan ();

   s_expression_tokenizer_core #(.MAX_TEXT(TEXT_LIMIT)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Lexer state mirrored by the predictor.
   mode_type    lx_mode;
   int          lx_length;
   logic        lx_digits;
   int          lx_dots;
   kw_type      lx_kw;
   logic        lx_over;

   lex_result_type awaited_results[$];
   int          results_this_byte;
   int          bytes_sent;
   int          productive_bytes;
   int          results_checked;
   int          mismatches;
   logic [8:0]  kinds_seen;
   logic        no_idle;
   int          stall_left = 0;

   string keyword_forms[8] = '{"#t", "#f", "#nil", "#n", "#ni", "#tf", "#nilx", "#"};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   function automatic void clear_word();
      lx_length = 0;
      lx_digits = 1'b1;
      lx_dots   = 0;
      lx_kw     = KW_START;
      lx_over   = 1'b0;
   endfunction

   function automatic void add_result(input kind_type k, input logic [7:0] ch,
                                      input logic [8:0] len, input logic tl);
      lex_result_type r;
      r.kind         = k;
      r.char_out     = ch;
      r.token_length = len;
      r.too_long     = tl;
      r.last         = 1'b0;
      awaited_results.push_back(r);
      results_this_byte++;
   endfunction

   // Length saturates at the limit; the overflow flag remembers that it did.
   function automatic void tally_byte();
      if (lx_length < TEXT_LIMIT) lx_length++;
      else lx_over = 1'b1;
   endfunction

   // Track digits, dots and how far a keyword prefix still matches.
   function automatic void classify_byte(input logic [7:0] b);
      if (b == CHAR_DOT) begin
         if (lx_dots < 2) lx_dots++;
      end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
         lx_digits = 1'b0;
      end
      case (lx_kw)
         KW_START: lx_kw = (b == CHAR_HASH) ? KW_HASH : KW_NONE;
         KW_HASH: begin
            if (b == CHAR_LOW_T) lx_kw = KW_T;
            else if (b == CHAR_LOW_F) lx_kw = KW_F;
            else if (b == CHAR_LOW_N) lx_kw = KW_N;
            else lx_kw = KW_NONE;
         end
         KW_N:    lx_kw = (b == CHAR_LOW_I) ? KW_NI : KW_NONE;
         KW_NI:   lx_kw = (b == CHAR_LOW_L) ? KW_NIL : KW_NONE;
         default: lx_kw = KW_NONE;
      endcase
   endfunction

   // Apply one accepted byte to the lexer and queue the results it causes.
   function automatic void lex_byte(input logic [7:0] b);
      logic        paren_byte;
      kind_type    paren_kind;
      kind_type    word_kind;
      lex_result_type tail;
      paren_byte = (b == CHAR_OPEN) || (b == CHAR_CLOSE);
      paren_kind = (b == CHAR_OPEN) ? KIND_OPEN : KIND_CLOSE;
      results_this_byte = 0;
      if (b == CHAR_END_LO || b == CHAR_END_HI) begin
         lx_mode = MODE_READ;
         clear_word();
      end else begin
         case (lx_mode)
            MODE_COMMENT: begin
               if (b == CHAR_NL) lx_mode = MODE_READ;
            end
            MODE_STRING: begin
               if (b == CHAR_QUOTE) begin
                  add_result(KIND_STRING, 8'd0, 9'(lx_length), lx_over);
                  lx_mode = MODE_READ;
                  clear_word();
               end else begin
                  tally_byte();
                  add_result(KIND_BYTE, b, 9'd0, 1'b0);
               end
            end
            MODE_TOKEN: begin
               if (paren_byte || b == CHAR_SEMI || is_blank(b)) begin
                  if (lx_kw == KW_NIL) word_kind = KIND_NIL;
                  else if (lx_kw == KW_T || lx_kw == KW_F) word_kind = KIND_BOOL;
                  else if (lx_digits && lx_dots == 1) word_kind = KIND_FLOAT;
                  else if (lx_digits && lx_dots == 0) word_kind = KIND_INT;
                  else word_kind = KIND_ID;
                  add_result(word_kind, 8'd0, 9'(lx_length), lx_over);
                  if (paren_byte) add_result(paren_kind, 8'd0, 9'd0, 1'b0);
                  lx_mode = (b == CHAR_SEMI) ? MODE_COMMENT : MODE_READ;
                  clear_word();
               end else begin
                  tally_byte();
                  classify_byte(b);
                  add_result(KIND_BYTE, b, 9'd0, 1'b0);
               end
            end
            default: begin
               if (paren_byte) begin
                  add_result(paren_kind, 8'd0, 9'd0, 1'b0);
               end else if (b == CHAR_SEMI) begin
                  lx_mode = MODE_COMMENT;
               end else if (is_blank(b)) begin
                  // Whitespace between tokens is dropped.
               end else if (b == CHAR_QUOTE) begin
                  clear_word();
                  lx_mode = MODE_STRING;
               end else begin
                  clear_word();
                  tally_byte();
                  classify_byte(b);
                  add_result(KIND_BYTE, b, 9'd0, 1'b0);
                  lx_mode = MODE_TOKEN;
               end
            end
         endcase
      end
      // The final result of this byte carries the last flag.
      if (results_this_byte > 0) begin
         tail = awaited_results.pop_back();
         tail.last = 1'b1;
         awaited_results.push_back(tail);
         productive_bytes++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic log_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   task automatic check_result();
      lex_result_type want;
      if (awaited_results.size() == 0) begin
         log_mismatch("result with nothing expected, kind", rsp_chan.kind, -1);
         return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      kinds_seen[int'(want.kind)] = 1'b1;
      if (rsp_chan.kind !== want.kind)
         log_mismatch("kind", rsp_chan.kind, want.kind);
      if (rsp_chan.char_out !== want.char_out)
         log_mismatch("char_out", rsp_chan.char_out, want.char_out);
      if (rsp_chan.token_length !== want.token_length)
         log_mismatch("token_length", rsp_chan.token_length, want.token_length);
      if (rsp_chan.too_long !== want.too_long)
         log_mismatch("too_long", rsp_chan.too_long, want.too_long);
      if (rsp_chan.last !== want.last)
         log_mismatch("last", rsp_chan.last, want.last);
   endtask

   // Every result transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_result();
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // The result side stalls at random unless a no-idle stretch is running.
   always @(negedge clock) begin
      if (no_idle || stall_left == 0) begin
         rsp_chan.ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end else begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end
   end

   // Offer one byte and hold it until the transfer happens.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.text_byte = b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      lex_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_run(input int count, input logic [7:0] b);
      repeat (count) send_byte(b);
   endtask

   // Stop sending and wait until every expected result has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] blank_char();
      return ($urandom_range(0, 3) == 0) ? CHAR_SPACE : 8'($urandom_range(9, 13));
   endfunction

   // Any byte that may sit inside a token; a quote only after the first byte.
   function automatic logic [7:0] token_char(input logic allow_quote);
      logic [7:0] b;
      b = 8'($urandom_range(1, 254));
      while (b == CHAR_OPEN || b == CHAR_CLOSE || b == CHAR_SEMI || is_blank(b) ||
             (!allow_quote && b == CHAR_QUOTE))
         b = 8'($urandom_range(1, 254));
      return b;
   endfunction

   function automatic logic [7:0] body_char(input logic [7:0] stop);
      logic [7:0] b;
      b = 8'($urandom_range(1, 254));
      while (b == stop) b = 8'($urandom_range(1, 254));
      return b;
   endfunction

   task automatic send_comment();
      send_byte(CHAR_SEMI);
      repeat ($urandom_range(0, 6)) send_byte(body_char(CHAR_NL));
      send_byte(CHAR_NL);
   endtask

   task automatic send_end_mark();
      send_byte($urandom_range(0, 1) ? CHAR_END_HI : CHAR_END_LO);
   endtask

   // Whatever ends a token: whitespace, a paren, a comment or end of text.
   task automatic send_delim();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) send_byte(blank_char());
      else if (r < 7) send_byte(CHAR_OPEN);
      else if (r == 7) send_byte(CHAR_CLOSE);
      else if (r == 8) send_comment();
      else send_end_mark();
   endtask

   task automatic send_number();
      int dots_left;
      dots_left = $urandom_range(0, 2);
      repeat ($urandom_range(1, 6)) begin
         if (dots_left > 0 && $urandom_range(0, 2) == 0) begin
            send_byte(CHAR_DOT);
            dots_left--;
         end else begin
            send_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
         end
      end
   endtask

   task automatic send_word();
      send_byte(token_char(1'b0));
      repeat ($urandom_range(0, 7)) send_byte(token_char(1'b1));
   endtask

   task automatic send_quoted();
      send_byte(CHAR_QUOTE);
      repeat ($urandom_range(0, 8)) send_byte(body_char(CHAR_QUOTE));
      send_byte(CHAR_QUOTE);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Parens, booleans and nil, ended by space and by parens; near-miss keywords.
   task automatic test_parens_keywords();
      send_text("(#t #f(#nil)");
      send_text("#tx #ni\015");
      wait_drained();
   endtask

   // Float, integer, a token ended by a comment, two dots, a lone dot,
   // high bytes and a quote inside a token.
   task automatic test_numbers_ids();
      send_text("1.5 42;x)\n1..2\t.\013");
      send_byte(8'h80);
      send_text("'a\014");
      wait_drained();
   endtask

   // Empty string, a string holding a paren and a newline, and end of text
   // inside a string, a token and a comment.
   task automatic test_strings_end_of_text();
      send_text("'' '(;a\n' 'x");
      send_byte(CHAR_END_HI);
      send_text("#n");
      send_byte(CHAR_END_LO);
      send_text(";c");
      send_byte(CHAR_END_LO);
      send_text("7 ");
      wait_drained();
   endtask

   // A token and a string just past the length limit.
   task automatic test_overlong();
      // A dot after saturation still turns the integer into a float.
      send_run(TEXT_LIMIT + 1, 8'h33);
      send_byte(CHAR_DOT);
      send_byte(CHAR_CLOSE);
      send_byte(CHAR_QUOTE);
      send_run(TEXT_LIMIT + 1, 8'hC3);
      send_byte(CHAR_QUOTE);
      wait_drained();
   endtask

   // Mostly well-formed text with random content, plus noise and cut-off runs.
   task automatic test_random_text();
      int  start;
      int  pick;
      logic paused;
      start  = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
         if (!paused && bytes_sent - start >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 20) begin
            send_byte($urandom_range(0, 1) ? CHAR_OPEN : CHAR_CLOSE);
         end else if (pick < 25) begin
            send_byte(blank_char());
         end else if (pick < 38) begin
            send_text(keyword_forms[$urandom_range(0, 7)]);
            send_delim();
         end else if (pick < 55) begin
            send_number();
            send_delim();
         end else if (pick < 72) begin
            send_word();
            send_delim();
         end else if (pick < 86) begin
            send_quoted();
         end else if (pick < 94) begin
            send_comment();
         end else begin
            // A token or string cut short by end of text.
            if ($urandom_range(0, 1)) send_byte(CHAR_QUOTE);
            send_word();
            send_end_mark();
         end
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.text_byte = 8'd0;
      no_idle            = 1'b0;
      bytes_sent         = 0;
      productive_bytes   = 0;
      results_checked    = 0;
      mismatches         = 0;
      kinds_seen         = '0;
      lx_mode            = MODE_READ;
      clear_word();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_parens_keywords();
      test_numbers_ids();
      test_strings_end_of_text();
      test_overlong();
      test_random_text();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         log_mismatch("results never delivered, count", 0, awaited_results.size());

      $display("Run covered %0d text bytes (%0d with results) and %0d checked results,",
               bytes_sent, productive_bytes, results_checked);
      $display("with %0d of 9 result kinds observed and %0d mismatches.",
               $countones(kinds_seen), mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/setok_pkg.sv
hw/rtl/setok_if.sv
hw/rtl/setok_front.sv
hw/rtl/setok_queue.sv
hw/rtl/setok_back.sv
hw/rtl/s_expression_tokenizer_core.sv
dv/s_expression_tokenizer_core_test.sv
